>>> design/four_level_page_table_walker_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-level page table walker core
// Checks are compiled in simulation and left out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define PGW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define PGW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define PGW_ASSERT_IMPL(label, ante, cons, msg)
`define PGW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> design/pgwalk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgwalk_pkg
// Types, widths and codes shared by the page table walker modules.
// ----------------------------------------------------------------------------
package pgwalk_pkg;

    localparam int LA_W    = 48;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = 64;
    localparam int IDX_W   = 9;
    localparam int LVL_W   = 3;

    // Walk level codes: idle, or which entry the walk is waiting for.
    localparam logic [LVL_W-1:0] LVL_IDLE = 3'd0;
    localparam logic [LVL_W-1:0] LVL_PML4 = 3'd1;
    localparam logic [LVL_W-1:0] LVL_PDPT = 3'd2;
    localparam logic [LVL_W-1:0] LVL_PD   = 3'd3;
    localparam logic [LVL_W-1:0] LVL_PT   = 3'd4;

    // Input mode codes.
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_ENTRY   = 1'b1;

    // Result kind codes.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Page size codes.
    localparam logic [1:0] PAGE_4K = 2'd0;
    localparam logic [1:0] PAGE_2M = 2'd1;
    localparam logic [1:0] PAGE_1G = 2'd2;

    // Entry attribute bit positions.
    localparam int BIT_P  = 0;
    localparam int BIT_PS = 7;

    // One result transaction.
    typedef struct packed {
        logic            kind;
        logic [PA_W-1:0] physical_address;
        logic            fault;
        logic [1:0]      page_kind;
        logic [1:0]      fault_level;
    } t_result;

    // What one item does to the walk.
    typedef struct packed {
        logic             emit;
        logic             load_la;
        logic [LVL_W-1:0] next_level;
    } t_step_ctl;

endpackage

>>> design/pgwalk_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgwalk_step
// Combinational decision for one item: checks the entry against the current
// walk level and forms the next read request or the finished translation.
// ----------------------------------------------------------------------------
module pgwalk_step (
    input  logic                               i_mode,
    input  logic [pgwalk_pkg::LA_W-1:0]        i_lin_addr,
    input  logic [pgwalk_pkg::ENTRY_W-1:0]     i_table_entry,
    input  logic [pgwalk_pkg::LVL_W-1:0]       i_level,
    input  logic [pgwalk_pkg::LA_W-1:0]        i_held_la,
    input  logic [pgwalk_pkg::PA_W-1:0]        i_root_base,
    output pgwalk_pkg::t_step_ctl              o_ctl,
    output pgwalk_pkg::t_result                o_result
);
    import pgwalk_pkg::*;

    logic             w_present;
    logic             w_large;
    logic [IDX_W-1:0] w_next_idx;
    logic [LVL_W-1:0] w_level;

    // Levels above the last one behave as idle.
    assign w_level   = (i_level > LVL_PT) ? LVL_IDLE : i_level;
    assign w_present = i_table_entry[BIT_P];
    assign w_large   = i_table_entry[BIT_PS];

    // Table index of the level that follows the current one.
    always_comb begin
        case (w_level)
            LVL_PML4: w_next_idx = i_held_la[38:30];
            LVL_PDPT: w_next_idx = i_held_la[29:21];
            LVL_PD:   w_next_idx = i_held_la[20:12];
            default:  w_next_idx = i_held_la[20:12];
        endcase
    end

    // Walk decision.
    always_comb begin
        o_ctl      = '{emit: 1'b0, load_la: 1'b0, next_level: w_level};
        o_result   = '{kind: KIND_READ, physical_address: '0, fault: 1'b0,
                       page_kind: PAGE_4K, fault_level: 2'd0};
        if (i_mode == MODE_REQUEST) begin
            if (w_level == LVL_IDLE) begin
                o_ctl.emit       = 1'b1;
                o_ctl.load_la    = 1'b1;
                o_ctl.next_level = LVL_PML4;
                o_result.physical_address =
                    {i_root_base[PA_W-1:12], i_lin_addr[47:39], 3'b000};
            end
        end else if (w_level != LVL_IDLE) begin
            o_ctl.emit = 1'b1;
            if (!w_present) begin
                // Missing entry ends the walk with a fault at this level.
                o_ctl.next_level     = LVL_IDLE;
                o_result.kind        = KIND_DONE;
                o_result.fault       = 1'b1;
                o_result.fault_level = 2'(w_level - LVL_PML4);
            end else if (w_level == LVL_PDPT && w_large) begin
                o_ctl.next_level          = LVL_IDLE;
                o_result.kind             = KIND_DONE;
                o_result.page_kind        = PAGE_1G;
                o_result.physical_address = {i_table_entry[51:30], i_held_la[29:0]};
            end else if (w_level == LVL_PD && w_large) begin
                o_ctl.next_level          = LVL_IDLE;
                o_result.kind             = KIND_DONE;
                o_result.page_kind        = PAGE_2M;
                o_result.physical_address = {i_table_entry[51:21], i_held_la[20:0]};
            end else if (w_level == LVL_PT) begin
                o_ctl.next_level          = LVL_IDLE;
                o_result.kind             = KIND_DONE;
                o_result.page_kind        = PAGE_4K;
                o_result.physical_address = {i_table_entry[51:12], i_held_la[11:0]};
            end else begin
                // Descend: read the next table's entry.
                o_ctl.next_level          = w_level + LVL_PML4;
                o_result.physical_address =
                    {i_table_entry[51:12], w_next_idx, 3'b000};
            end
        end
    end

endmodule

>>> design/four_level_page_table_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Walks four-level x86-64 page tables one entry per transaction.
// ----------------------------------------------------------------------------
// A translate transaction (tuser = 0) starts a walk and yields a read request
// for the PML4 entry; each returned entry (tuser = 1) yields the next read
// request or the finished translation, with fault, page size and fault level.
// Every input transaction passes an input register, one level of decode
// logic and an output register, so the block takes one transaction per
// clock while the output is not stalled and presents its result from the
// output register. Requests during a walk and entries while idle give no
// result.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_core_macros.svh"

module four_level_page_table_walker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration: root table base
    input  logic                           i_cfg_we,
    input  logic [pgwalk_pkg::PA_W-1:0]    i_cfg_wdata,
    // Input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [111:0]                   i_s_tdata,  // lin_addr, table_entry
    input  logic                           i_s_tuser,  // mode
    // Output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [63:0]                    o_m_tdata,  // physical_address, fault,
                                                       // page_kind, fault_level, zero pad
    output logic                           o_m_tuser   // kind
);
    import pgwalk_pkg::*;

    logic [PA_W-1:0]    r_root_base;
    logic [LVL_W-1:0]   r_walk_level;
    logic [LA_W-1:0]    r_held_la;
    logic               r_in_valid;
    logic               r_in_mode;
    logic [LA_W-1:0]    r_in_la;
    logic [ENTRY_W-1:0] r_in_entry;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_out_free;
    logic               w_advance;
    t_step_ctl          w_ctl;
    t_result            w_result;

    // Handshake: the input stage moves on whenever the output register is free.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_base <= '0;
        end else if (i_cfg_we) begin
            r_root_base <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode  <= i_s_tuser;
            r_in_la    <= i_s_tdata[LA_W-1:0];
            r_in_entry <= i_s_tdata[LA_W +: ENTRY_W];
        end
    end

    // Walk decision logic.
    pgwalk_step u_step (
        .i_mode           (r_in_mode),
        .i_lin_addr       (r_in_la),
        .i_table_entry    (r_in_entry),
        .i_level          (r_walk_level),
        .i_held_la        (r_held_la),
        .i_root_base      (r_root_base),
        .o_ctl            (w_ctl),
        .o_result         (w_result)
    );

    // Walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_level <= LVL_IDLE;
            r_held_la    <= '0;
        end else if (w_advance) begin
            r_walk_level <= w_ctl.next_level;
            if (w_ctl.load_la) begin
                r_held_la <= r_in_la;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_ctl.emit) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {7'b0, r_out.fault_level, r_out.page_kind, r_out.fault,
                         r_out.physical_address};

    // Checks on the walk logic.
    `PGW_ASSERT_IMPL(a_fault_clean, r_out_valid && r_out.fault, r_out.physical_address == '0 && r_out.page_kind == PAGE_4K && r_out.kind == KIND_DONE, "fault result carries address or page size")
    `PGW_ASSERT_IMPL(a_read_in_walk, r_out_valid && r_out.kind == KIND_READ, r_walk_level != LVL_IDLE, "read request pending while walker idle")
    `PGW_ASSERT_IMPL(a_done_idle, r_out_valid && r_out.kind == KIND_DONE, r_walk_level == LVL_IDLE, "finished result pending while walk active")
    `PGW_ASSERT_NEXT(a_start_walk, w_advance && r_in_mode == MODE_REQUEST && r_walk_level == LVL_IDLE, r_walk_level == LVL_PML4 && r_out_valid, "request did not start a walk")

endmodule
